>>> design/uvs_pkg.sv
// Shared types, constants and arithmetic helpers for the UV sphere vertex generator.
`default_nettype none

package uvs_pkg;

  // Widths fixed by the word formats.
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned REM_W      = 12;
  localparam int unsigned QUO_W      = 33;
  localparam int unsigned CFG_ADDR_W = 5;

  // One in Q1.30 and pi scaled by 2^32.
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [33:0] PI_Q32  = 34'd13493037705;

  // Reciprocal multiply shift: exact floor division of 30-bit values by divisors up to 128.
  localparam int unsigned RECIP_SHIFT = 37;

  // Horner series divisors, one pair per cell, sine and cosine.
  localparam int unsigned HORNER_STEPS = 4;
  localparam int unsigned SIN_DIV [HORNER_STEPS] = '{72, 42, 20, 6};
  localparam int unsigned COS_DIV [HORNER_STEPS] = '{90, 56, 30, 12};

  localparam logic signed [63:0] POS_MIN  = -64'sd2147483648;
  localparam logic signed [63:0] POS_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] NORM_MIN = -64'sd32768;
  localparam logic signed [63:0] NORM_MAX = 64'sd32767;

  // Register map, one register every four bytes.
  typedef enum logic [2:0] {
    REG_RADIUS,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_SEGMENTS,
    REG_RINGS
  } uvs_reg_t;

  // Quadrant of a turn angle.
  typedef enum logic [1:0] {
    QUAD_FIRST,
    QUAD_SECOND,
    QUAD_THIRD,
    QUAD_FOURTH
  } uvs_quad_t;

  typedef struct packed {
    logic [CNT_W-1:0] ring_index;
    logic [CNT_W-1:0] segment_index;
  } uvs_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               index_out_of_range;
  } uvs_vertex_t;

  // Word travelling through the divider cells.
  typedef struct packed {
    logic             oor;
    logic [REM_W-1:0] rem_phi;
    logic [REM_W-1:0] rem_psi;
    logic [QUO_W-1:0] quo_phi;
    logic [QUO_W-1:0] quo_psi;
  } uvs_div_t;

  // One angle while its series is evaluated.
  typedef struct packed {
    uvs_quad_t   quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] ws;
    logic [30:0] wc;
  } uvs_lane_t;

  typedef struct packed {
    logic      oor;
    uvs_lane_t phi;
    uvs_lane_t psi;
  } uvs_poly_t;

  // Divide by 2^sh, rounding half away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic signed [63:0] half;
    logic signed [63:0] mask;
    half = 64'sd1 <<< (sh - 1);
    mask = (64'sd1 <<< sh) - 64'sd1;
    if (v >= 64'sd0) begin
      return (v + half) >>> sh;
    end
    return (v - half + mask) >>> sh;
  endfunction

  function automatic logic signed [63:0] sat_s(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> design/uvs_div_cell.sv
// One restoring division step for both angles: one quotient bit per cell.
`default_nettype none

module uvs_div_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [uvs_pkg::CNT_W-1:0]     count_phi,
  input  logic [uvs_pkg::CNT_W-1:0]     count_psi,
  input  logic                          src_valid,
  output logic                          src_stall,
  input  uvs_pkg::uvs_div_t             src,
  output logic                          dst_valid,
  input  logic                          dst_stall,
  output uvs_pkg::uvs_div_t             dst
);
  import uvs_pkg::*;

  logic             ge_phi;
  logic             ge_psi;
  logic [REM_W-1:0] diff_phi;
  logic [REM_W-1:0] diff_psi;
  uvs_div_t         dst_next;

  // Compare, subtract and double the partial remainder.
  always_comb begin
    ge_phi   = src.rem_phi >= REM_W'(count_phi);
    ge_psi   = src.rem_psi >= REM_W'(count_psi);
    diff_phi = ge_phi ? src.rem_phi - REM_W'(count_phi) : src.rem_phi;
    diff_psi = ge_psi ? src.rem_psi - REM_W'(count_psi) : src.rem_psi;
    dst_next.oor     = src.oor;
    dst_next.rem_phi = {diff_phi[REM_W-2:0], 1'b0};
    dst_next.rem_psi = {diff_psi[REM_W-2:0], 1'b0};
    dst_next.quo_phi = {src.quo_phi[QUO_W-2:0], ge_phi};
    dst_next.quo_psi = {src.quo_psi[QUO_W-2:0], ge_psi};
  end

  assign src_stall = dst_valid && dst_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (!src_stall) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall) begin
      dst <= dst_next;
    end
  end

endmodule

`default_nettype wire

>>> design/uvs_angle_cell.sv
// Turns quotients into folded angles in radians and their squares.
`default_nettype none

module uvs_angle_cell #(
  parameter int unsigned ANGLE_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  uvs_pkg::uvs_div_t src,
  output logic              dst_valid,
  input  logic              dst_stall,
  output uvs_pkg::uvs_poly_t dst
);
  import uvs_pkg::*;

  localparam int unsigned TURN_SHIFT = 32 - ANGLE_BITS;

  logic [31:0] turn [2];
  logic [29:0] frac [2];
  logic [29:0] fold [2];
  logic        swp  [2];
  logic [63:0] xprod [2];
  logic [29:0] xs   [2];

  logic        v1;
  logic        stall1;
  logic        src_stall_dn;
  logic        oor1;
  uvs_quad_t   quad1 [2];
  logic        swap1 [2];
  logic [29:0] x1    [2];

  logic [59:0] sq [2];
  uvs_poly_t   dst_next;

  // Stage one: turn angles, fold to an eighth turn, scale to radians.
  always_comb begin
    turn[0] = 32'(src.quo_phi << TURN_SHIFT);
    turn[1] = 32'((src.quo_psi >> 1) << TURN_SHIFT) + 32'hC000_0000;
    for (int k = 0; k < 2; k++) begin
      frac[k]  = turn[k][29:0];
      swp[k]   = frac[k] > 30'h2000_0000;
      fold[k]  = swp[k] ? 30'(31'h4000_0000 - {1'b0, frac[k]}) : frac[k];
      xprod[k] = {34'b0, fold[k]} * {30'b0, PI_Q32};
      xs[k]    = 30'(xprod[k] >> 33);
    end
  end

  assign stall1 = v1 && src_stall_dn;

  assign src_stall_dn = dst_valid && dst_stall;
  assign src_stall    = stall1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!stall1) begin
      v1 <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall1) begin
      oor1 <= src.oor;
      for (int k = 0; k < 2; k++) begin
        quad1[k] <= uvs_quad_t'(turn[k][31:30]);
        swap1[k] <= swp[k];
        x1[k]    <= xs[k];
      end
    end
  end

  // Stage two: square of each angle, series accumulators start at one.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sq[k] = {30'b0, x1[k]} * {30'b0, x1[k]};
    end
    dst_next.oor     = oor1;
    dst_next.phi.quad = quad1[0];
    dst_next.phi.swap = swap1[0];
    dst_next.phi.x    = x1[0];
    dst_next.phi.x2   = 30'(sq[0] >> 30);
    dst_next.phi.ws   = Q30_ONE;
    dst_next.phi.wc   = Q30_ONE;
    dst_next.psi.quad = quad1[1];
    dst_next.psi.swap = swap1[1];
    dst_next.psi.x    = x1[1];
    dst_next.psi.x2   = 30'(sq[1] >> 30);
    dst_next.psi.ws   = Q30_ONE;
    dst_next.psi.wc   = Q30_ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (!src_stall_dn) begin
      dst_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall_dn) begin
      dst <= dst_next;
    end
  end

endmodule

`default_nettype wire

>>> design/uvs_horner_cell.sv
// One Horner step of the sine and cosine series for both angles.
`default_nettype none

module uvs_horner_cell #(
  parameter int unsigned DIV_SIN = 72,
  parameter int unsigned DIV_COS = 90
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  uvs_pkg::uvs_poly_t src,
  output logic               dst_valid,
  input  logic               dst_stall,
  output uvs_pkg::uvs_poly_t dst
);
  import uvs_pkg::*;

  localparam logic [35:0] RECIP_SIN =
    36'(((64'd1 << RECIP_SHIFT) + 64'(DIV_SIN) - 64'd1) / 64'(DIV_SIN));
  localparam logic [35:0] RECIP_COS =
    36'(((64'd1 << RECIP_SHIFT) + 64'(DIV_COS) - 64'd1) / 64'(DIV_COS));

  logic        v1;
  logic        stall1;
  logic        stall2;
  uvs_poly_t   mid;
  uvs_poly_t   mid_next;
  uvs_poly_t   dst_next;
  logic [60:0] mprod [4];
  logic [65:0] dprod [4];

  // Multiply stage: accumulators times the squared angle.
  always_comb begin
    mid_next = src;
    mprod[0] = {31'b0, src.phi.x2} * {30'b0, src.phi.ws};
    mprod[1] = {31'b0, src.phi.x2} * {30'b0, src.phi.wc};
    mprod[2] = {31'b0, src.psi.x2} * {30'b0, src.psi.ws};
    mprod[3] = {31'b0, src.psi.x2} * {30'b0, src.psi.wc};
    mid_next.phi.ws = 31'(mprod[0] >> 30);
    mid_next.phi.wc = 31'(mprod[1] >> 30);
    mid_next.psi.ws = 31'(mprod[2] >> 30);
    mid_next.psi.wc = 31'(mprod[3] >> 30);
  end

  // Divide stage: exact floor division by reciprocal, then one minus.
  always_comb begin
    dst_next = mid;
    dprod[0] = {35'b0, mid.phi.ws} * {30'b0, RECIP_SIN};
    dprod[1] = {35'b0, mid.phi.wc} * {30'b0, RECIP_COS};
    dprod[2] = {35'b0, mid.psi.ws} * {30'b0, RECIP_SIN};
    dprod[3] = {35'b0, mid.psi.wc} * {30'b0, RECIP_COS};
    dst_next.phi.ws = Q30_ONE - 31'(dprod[0] >> RECIP_SHIFT);
    dst_next.phi.wc = Q30_ONE - 31'(dprod[1] >> RECIP_SHIFT);
    dst_next.psi.ws = Q30_ONE - 31'(dprod[2] >> RECIP_SHIFT);
    dst_next.psi.wc = Q30_ONE - 31'(dprod[3] >> RECIP_SHIFT);
  end

  assign stall2    = dst_valid && dst_stall;
  assign stall1    = v1 && stall2;
  assign src_stall = stall1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (!stall1) begin
        v1 <= src_valid;
      end
      if (!stall2) begin
        dst_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall1) begin
      mid <= mid_next;
    end
    if (!stall2) begin
      dst <= dst_next;
    end
  end

endmodule

`default_nettype wire

>>> design/uvs_vertex_cell.sv
// Finishes the series, forms the direction and scales it to position and normal.
`default_nettype none

module uvs_vertex_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [30:0]          radius,
  input  logic signed [31:0]   center_x,
  input  logic signed [31:0]   center_y,
  input  logic signed [31:0]   center_z,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  uvs_pkg::uvs_poly_t   src,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output uvs_pkg::uvs_vertex_t dst
);
  import uvs_pkg::*;

  uvs_lane_t          lane  [2];
  logic [60:0]        sprod [2];
  logic [60:0]        cprod [2];
  logic [31:0]        s0    [2];
  logic [31:0]        c0    [2];
  logic signed [31:0] sa    [2];
  logic signed [31:0] ca    [2];
  logic signed [31:0] sn    [2];
  logic signed [31:0] cs    [2];

  logic               v1, v2, v3, v4;
  logic               stall1, stall2, stall3, stall4, stall5;
  logic               oor1, oor2, oor3, oor4;
  logic signed [31:0] sin_phi, cos_phi, sin_psi, cos_psi;
  logic signed [63:0] prod_x, prod_y;
  logic signed [31:0] sin_psi2;
  logic signed [31:0] dir [3];
  logic signed [63:0] scaled [3];
  logic signed [15:0] norm [3];
  logic signed [63:0] ctr [3];
  logic signed [31:0] pos [3];
  uvs_vertex_t        dst_next;

  // Stage one: last series terms, undo the fold and place in the quadrant.
  always_comb begin
    lane[0] = src.phi;
    lane[1] = src.psi;
    for (int k = 0; k < 2; k++) begin
      sprod[k] = {31'b0, lane[k].x} * {30'b0, lane[k].ws};
      cprod[k] = {31'b0, lane[k].x2} * {30'b0, lane[k].wc};
      s0[k]    = 32'(sprod[k] >> 30);
      c0[k]    = 32'(Q30_ONE) - 32'(cprod[k] >> 31);
      sa[k]    = lane[k].swap ? c0[k] : s0[k];
      ca[k]    = lane[k].swap ? s0[k] : c0[k];
      case (lane[k].quad)
        QUAD_FIRST: begin
          sn[k] = sa[k];
          cs[k] = ca[k];
        end
        QUAD_SECOND: begin
          sn[k] = ca[k];
          cs[k] = -sa[k];
        end
        QUAD_THIRD: begin
          sn[k] = -sa[k];
          cs[k] = -ca[k];
        end
        default: begin
          sn[k] = -ca[k];
          cs[k] = sa[k];
        end
      endcase
    end
  end

  assign stall5    = dst_valid && dst_stall;
  assign stall4    = v4 && stall5;
  assign stall3    = v3 && stall4;
  assign stall2    = v2 && stall3;
  assign stall1    = v1 && stall2;
  assign src_stall = stall1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (!stall1) v1 <= src_valid;
      if (!stall2) v2 <= v1;
      if (!stall3) v3 <= v2;
      if (!stall4) v4 <= v3;
      if (!stall5) dst_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall1) begin
      oor1    <= src.oor;
      sin_phi <= sn[0];
      cos_phi <= cs[0];
      sin_psi <= sn[1];
      cos_psi <= cs[1];
    end
  end

  // Stage two: horizontal direction products.
  always_ff @(posedge clk) begin
    if (!stall2) begin
      oor2     <= oor1;
      prod_x   <= 64'(cos_psi) * 64'(cos_phi);
      prod_y   <= 64'(cos_psi) * 64'(sin_phi);
      sin_psi2 <= sin_psi;
    end
  end

  // Stage three: round the direction back to Q2.30.
  always_ff @(posedge clk) begin
    if (!stall3) begin
      oor3   <= oor2;
      dir[0] <= 32'(rnd_shift(prod_x, 30));
      dir[1] <= 32'(rnd_shift(prod_y, 30));
      dir[2] <= sin_psi2;
    end
  end

  // Stage four: scale by the radius and form the normals.
  always_ff @(posedge clk) begin
    if (!stall4) begin
      oor4 <= oor3;
      for (int k = 0; k < 3; k++) begin
        scaled[k] <= 64'($signed({1'b0, radius})) * 64'(dir[k]);
        norm[k]   <= 16'(sat_s(rnd_shift(64'(dir[k]), 15), NORM_MIN, NORM_MAX));
      end
    end
  end

  // Stage five: add the centre, saturate, clear the word when out of range.
  always_comb begin
    ctr[0] = 64'(center_x);
    ctr[1] = 64'(center_y);
    ctr[2] = 64'(center_z);
    for (int k = 0; k < 3; k++) begin
      pos[k] = 32'(sat_s(rnd_shift(scaled[k], 30) + ctr[k], POS_MIN, POS_MAX));
    end
    if (oor4) begin
      dst_next = '0;
      dst_next.index_out_of_range = 1'b1;
    end else begin
      dst_next.pos_x              = pos[0];
      dst_next.pos_y              = pos[1];
      dst_next.pos_z              = pos[2];
      dst_next.normal_x           = norm[0];
      dst_next.normal_y           = norm[1];
      dst_next.normal_z           = norm[2];
      dst_next.index_out_of_range = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall5) begin
      dst <= dst_next;
    end
  end

endmodule

`default_nettype wire

>>> design/uv_sphere_vertex_generator_core.sv
// Top level of the UV sphere vertex generator: registers, divider chain and series chain.
//
// Usage: an item word carries a ring index and a segment index. It is taken on a
// rising edge with item_valid high and item_stall low. For each item one vertex word
// leaves on the vertex channel, taken when vertex_valid is high and vertex_stall low.
// Words leave in the order they arrived.
// Pipeline: one divider cell per quotient bit (ANGLE_BITS + 1), two angle stages,
// two stages in each of the four series cells and five vertex stages.
// Throughput: one item per cycle while no stall holds the chain; every cell takes a new word each cycle unless stalled.
// Stalling: a held vertex word stalls only the cells behind it up to the first
// empty cell, so empty slots keep filling; item_stall rises once the chain is full.
// Reset: rst clears all valid flags and loads the register defaults (radius 1.0,
// centre at the origin, 24 segments and 24 rings). The user must write the registers over
// the APB-style port only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module uv_sphere_vertex_generator_core #(
  parameter int unsigned MAX_STEPS  = 1024,
  parameter int unsigned ANGLE_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [uvs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  uvs_pkg::uvs_item_t                 item,
  output logic                               vertex_valid,
  input  logic                               vertex_stall,
  output uvs_pkg::uvs_vertex_t               vertex
);
  import uvs_pkg::*;

  localparam int unsigned DIV_CELLS = ANGLE_BITS + 1;

  logic [30:0]        radius;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [CNT_W-1:0]   segments_around;
  logic [CNT_W-1:0]   rings;
  logic               cfg_write;
  logic [CNT_W-1:0]   count_phi;
  logic [CNT_W-1:0]   count_psi;

  logic               div_valid [DIV_CELLS+1];
  logic               div_stall [DIV_CELLS+1];
  uvs_div_t           div_word  [DIV_CELLS+1];

  logic               poly_valid [HORNER_STEPS+1];
  logic               poly_stall [HORNER_STEPS+1];
  uvs_poly_t          poly_word  [HORNER_STEPS+1];

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
    if (n == '0) begin
      return CNT_W'(1);
    end
    if (32'(n) > MAX_STEPS) begin
      return CNT_W'(MAX_STEPS);
    end
    return n;
  endfunction

  // Register port: writes complete in the access phase, reads are combinational.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius          <= 31'd65536;
      center_x        <= '0;
      center_y        <= '0;
      center_z        <= '0;
      segments_around <= CNT_W'(24);
      rings           <= CNT_W'(24);
    end else if (cfg_write) begin
      unique case (uvs_reg_t'(paddr[4:2]))
        REG_RADIUS:   radius          <= pwdata[30:0];
        REG_CENTER_X: center_x        <= pwdata;
        REG_CENTER_Y: center_y        <= pwdata;
        REG_CENTER_Z: center_z        <= pwdata;
        REG_SEGMENTS: segments_around <= pwdata[CNT_W-1:0];
        REG_RINGS:    rings           <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (uvs_reg_t'(paddr[4:2]))
      REG_RADIUS:   prdata = {1'b0, radius};
      REG_CENTER_X: prdata = center_x;
      REG_CENTER_Y: prdata = center_y;
      REG_CENTER_Z: prdata = center_z;
      REG_SEGMENTS: prdata = 32'(segments_around);
      REG_RINGS:    prdata = 32'(rings);
      default:      prdata = '0;
    endcase
  end

  // Effective counts and the range check on the incoming word.
  assign count_phi = eff_count(segments_around);
  assign count_psi = eff_count(rings);

  always_comb begin
    div_word[0].oor     = (item.segment_index > count_phi) || (item.ring_index > count_psi);
    div_word[0].rem_phi = REM_W'(item.segment_index);
    div_word[0].rem_psi = REM_W'(item.ring_index);
    div_word[0].quo_phi = '0;
    div_word[0].quo_psi = '0;
  end

  assign div_valid[0] = item_valid;
  assign item_stall   = div_stall[0];

  // Divider chain: one quotient bit per cell.
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    uvs_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .count_phi (count_phi),
      .count_psi (count_psi),
      .src_valid (div_valid[i]),
      .src_stall (div_stall[i]),
      .src       (div_word[i]),
      .dst_valid (div_valid[i+1]),
      .dst_stall (div_stall[i+1]),
      .dst       (div_word[i+1])
    );
  end

  uvs_angle_cell #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_angle (
    .clk       (clk),
    .rst       (rst),
    .src_valid (div_valid[DIV_CELLS]),
    .src_stall (div_stall[DIV_CELLS]),
    .src       (div_word[DIV_CELLS]),
    .dst_valid (poly_valid[0]),
    .dst_stall (poly_stall[0]),
    .dst       (poly_word[0])
  );

  // Series chain: one Horner step per cell.
  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    uvs_horner_cell #(
      .DIV_SIN (SIN_DIV[i]),
      .DIV_COS (COS_DIV[i])
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .src_valid (poly_valid[i]),
      .src_stall (poly_stall[i]),
      .src       (poly_word[i]),
      .dst_valid (poly_valid[i+1]),
      .dst_stall (poly_stall[i+1]),
      .dst       (poly_word[i+1])
    );
  end

  uvs_vertex_cell u_vertex (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .src_valid (poly_valid[HORNER_STEPS]),
    .src_stall (poly_stall[HORNER_STEPS]),
    .src       (poly_word[HORNER_STEPS]),
    .dst_valid (vertex_valid),
    .dst_stall (vertex_stall),
    .dst       (vertex)
  );

`ifndef SYNTH
  // The input is held back only by a vertex word that is waiting.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (vertex_valid && vertex_stall))
    else $error("item stall without a waiting vertex word");

  // An out-of-range word carries nothing but its flag.
  a_oor_clear: assert property (@(posedge clk) disable iff (rst)
    (vertex_valid && vertex.index_out_of_range) |->
      (vertex.pos_x == 0 && vertex.pos_y == 0 && vertex.pos_z == 0 &&
       vertex.normal_x == 0 && vertex.normal_y == 0 && vertex.normal_z == 0))
    else $error("out-of-range vertex word has non-zero fields");

  // Nothing leaves in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !vertex_valid)
    else $error("vertex word valid straight after reset");
`endif

endmodule

`default_nettype wire
